@@ sv/dbht_pkg.sv @@
// Shared types, constants and helper functions for the doubling bucket hash table.
`default_nettype none

package dbht_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int SLOTS     = 4;
    localparam int KEY_WIDTH = 32;

    localparam int BKT_W    = MAX_DEPTH;
    localparam int NBUCKETS = 1 << MAX_DEPTH;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int ADDR_W   = BKT_W + SLOT_W;
    localparam int DEPTH_W  = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [DEPTH_W-1:0] global_depth;
    } rsp_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [KEY_WIDTH-1:0] data;
    } ram_wr_t;

    // Low d bits set: picks the bucket bits of a key.
    function automatic logic [BKT_W-1:0] depth_mask(input logic [DEPTH_W-1:0] d);
        logic [BKT_W-1:0] m;
        for (int j = 0; j < BKT_W; j++) begin
            m[j] = (j < int'(d));
        end
        return m;
    endfunction

    // Lowest clear slot, SLOTS when the bucket is full.
    function automatic logic [CNT_W-1:0] first_free(input logic [SLOTS-1:0] v);
        logic [CNT_W-1:0] r;
        logic             hit;
        r   = CNT_W'(SLOTS);
        hit = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!hit && !v[s]) begin
                r   = CNT_W'(s);
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    // Low n slots set: valid mask of a bucket filled in order.
    function automatic logic [SLOTS-1:0] fill_mask(input logic [CNT_W-1:0] n);
        logic [SLOTS-1:0] m;
        for (int s = 0; s < SLOTS; s++) begin
            m[s] = (s < int'(n));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ sv/dbht_key_ram.sv @@
// Key store: one write port, one registered read port.
`default_nettype none

module dbht_key_ram (
    input  wire logic                           clk,
    input  wire dbht_pkg::ram_wr_t              wr,
    input  wire logic [dbht_pkg::ADDR_W-1:0]    rd_addr,
    output logic      [dbht_pkg::KEY_WIDTH-1:0] rd_data
);
    import dbht_pkg::*;

    logic [KEY_WIDTH-1:0] key_mem [1 << ADDR_W];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/doubling_bucket_hash_table.sv @@
// Top level of the doubling bucket hash table: sequencer, valid bits, depth and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_stall | op, key
//   rsp     | out       | rsp_valid/rsp_stall | status, global_depth
//
// One request at a time. Insert into a bucket with room: S_INS places the key, then S_DONE.
// Remove/search: S_LK_RD skips empty slots and reads each valid one, S_LK_CMP compares it;
// a miss follows the last slot. The key store's single read port takes one slot at a time.
// A full bucket below MAX_DEPTH grows the table: the valid slots of each of the 2^old_depth
// old buckets are read and rewritten to their bucket (S_GR_RD, S_GR_WR), then retry.
// Reset sets depth to 1; the clearing state S_CLR then zeroes the valid words of buckets 0
// and 1, higher buckets are rewritten by a grow before they are ever read.
// A stalled response holds in its register; a new request is taken meanwhile.
`default_nettype none

module doubling_bucket_hash_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire dbht_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output dbht_pkg::rsp_t      rsp
);
    import dbht_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;   // place key or start a grow
    localparam logic [2:0] S_LK_RD  = 3'd2;   // issue read of next valid slot
    localparam logic [2:0] S_LK_CMP = 3'd3;   // compare read key
    localparam logic [2:0] S_GR_RD  = 3'd4;   // grow: read next valid slot
    localparam logic [2:0] S_GR_WR  = 3'd5;   // grow: rewrite key to its bucket
    localparam logic [2:0] S_DONE   = 3'd6;   // hand result to output register
    localparam logic [2:0] S_CLR    = 3'd7;   // after reset: clear buckets 0 and 1

    typedef struct packed {
        logic             en;
        logic [BKT_W-1:0] idx;
        logic [SLOTS-1:0] data;
    } vld_wr_t;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [1:0]           status_reg, status_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]     slot_reg, slot_next;
    logic [BKT_W-1:0]     gi_reg, gi_next;
    logic [BKT_W-1:0]     half_reg, half_next;
    logic [CNT_W-1:0]     cnt_lo_reg, cnt_lo_next;
    logic [CNT_W-1:0]     cnt_hi_reg, cnt_hi_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [SLOTS-1:0]     slot_valid_mem [NBUCKETS];
    logic [SLOTS-1:0]     vld_rd_reg;
    logic [BKT_W-1:0]     vld_rd_addr;

    vld_wr_t              vw0, vw1;
    ram_wr_t              ram_wr;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    logic [BKT_W-1:0]     cur_bkt;
    logic [SLOTS-1:0]     cur_vld;
    logic [SLOTS-1:0]     gi_vld;
    logic [CNT_W-1:0]     ff;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 gr_hi;
    logic [BKT_W-1:0]     gr_dst;
    logic [CNT_W-1:0]     gr_cnt;
    logic                 rsp_free;

    dbht_key_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Valid words come from a registered read addressed by the next state,
    // so the word of the bucket in use is ready in the state that needs it.
    assign vld_rd_addr = (state_next == S_GR_RD || state_next == S_GR_WR) ? gi_next
                       : (key_next[BKT_W-1:0] & depth_mask(depth_next));

    assign cur_bkt  = key_reg[BKT_W-1:0] & depth_mask(depth_reg);
    assign cur_vld  = vld_rd_reg;
    assign gi_vld   = vld_rd_reg;
    assign ff       = first_free(cur_vld);
    assign slot_idx = slot_reg[SLOT_W-1:0];

    // On a grow, the new top bucket bit sends a key to its twin bucket.
    assign gr_hi  = (ram_rd_data[BKT_W-1:0] & half_reg) != '0;
    assign gr_dst = gr_hi ? (gi_reg | half_reg) : gi_reg;
    assign gr_cnt = gr_hi ? cnt_hi_reg : cnt_lo_reg;

    assign ram_rd_addr = (state_reg == S_LK_RD) ? {cur_bkt, slot_idx} : {gi_reg, slot_idx};

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        depth_next     = depth_reg;
        slot_next      = slot_reg;
        gi_next        = gi_reg;
        half_next      = half_reg;
        cnt_lo_next    = cnt_lo_reg;
        cnt_hi_next    = cnt_hi_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        vw0            = '0;
        vw1            = '0;
        ram_wr         = '0;

        case (state_reg)
            S_CLR:
            begin
                // depth 1 uses buckets 0 and 1 only
                vw0.en     = 1'b1;
                vw0.idx    = '0;
                vw1.en     = 1'b1;
                vw1.idx    = BKT_W'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req.op;
                    key_next  = req.key[KEY_WIDTH-1:0];
                    slot_next = '0;
                    case (req.op)
                        OP_INSERT: state_next = S_INS;
                        OP_REMOVE: state_next = S_LK_RD;
                        OP_SEARCH: state_next = S_LK_RD;
                        default:
                        begin
                            status_next = ST_MISS;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (cur_vld != '1)
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = {cur_bkt, ff[SLOT_W-1:0]};
                    ram_wr.data = key_reg;
                    vw0.en      = 1'b1;
                    vw0.idx     = cur_bkt;
                    vw0.data    = cur_vld | (SLOTS'(1) << ff[SLOT_W-1:0]);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else if (depth_reg >= DEPTH_W'(MAX_DEPTH))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    depth_next  = depth_reg + DEPTH_W'(1);
                    half_next   = depth_mask(depth_reg) + BKT_W'(1);
                    gi_next     = '0;
                    slot_next   = '0;
                    cnt_lo_next = '0;
                    cnt_hi_next = '0;
                    state_next  = S_GR_RD;
                end
            end

            S_LK_RD:
            begin
                if (slot_reg == CNT_W'(SLOTS))
                begin
                    status_next = ST_MISS;
                    state_next  = S_DONE;
                end
                else if (cur_vld[slot_idx])
                begin
                    state_next = S_LK_CMP;
                end
                else
                begin
                    slot_next = slot_reg + CNT_W'(1);
                end
            end

            S_LK_CMP:
            begin
                if (ram_rd_data == key_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        vw0.en   = 1'b1;
                        vw0.idx  = cur_bkt;
                        vw0.data = cur_vld & ~(SLOTS'(1) << slot_idx);
                    end
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    slot_next  = slot_reg + CNT_W'(1);
                    state_next = S_LK_RD;
                end
            end

            S_GR_RD:
            begin
                if (slot_reg == CNT_W'(SLOTS))
                begin
                    // bucket done: both halves are filled from slot 0 up
                    vw0.en      = 1'b1;
                    vw0.idx     = gi_reg;
                    vw0.data    = fill_mask(cnt_lo_reg);
                    vw1.en      = 1'b1;
                    vw1.idx     = gi_reg | half_reg;
                    vw1.data    = fill_mask(cnt_hi_reg);
                    slot_next   = '0;
                    cnt_lo_next = '0;
                    cnt_hi_next = '0;
                    if (gi_reg == half_reg - BKT_W'(1))
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        gi_next = gi_reg + BKT_W'(1);
                    end
                end
                else if (gi_vld[slot_idx])
                begin
                    state_next = S_GR_WR;
                end
                else
                begin
                    slot_next = slot_reg + CNT_W'(1);
                end
            end

            S_GR_WR:
            begin
                // target slot never passes the slot just read, so in place is safe
                ram_wr.en   = 1'b1;
                ram_wr.addr = {gr_dst, gr_cnt[SLOT_W-1:0]};
                ram_wr.data = ram_rd_data;
                if (gr_hi)
                begin
                    cnt_hi_next = cnt_hi_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_lo_next = cnt_lo_reg + CNT_W'(1);
                end
                slot_next  = slot_reg + CNT_W'(1);
                state_next = S_GR_RD;
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.status          = status_reg;
                    rsp_next.global_depth    = depth_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            depth_reg     <= DEPTH_W'(1);
            slot_reg      <= '0;
            gi_reg        <= '0;
            half_reg      <= '0;
            cnt_lo_reg    <= '0;
            cnt_hi_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            slot_reg      <= slot_next;
            gi_reg        <= gi_next;
            half_reg      <= half_next;
            cnt_lo_reg    <= cnt_lo_next;
            cnt_hi_reg    <= cnt_hi_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // per-bucket slot valid words: two write ports, one registered read port;
    // a write to the address being read is passed straight to the read register
    always_ff @(posedge clk)
    begin
        if (vw0.en)
        begin
            slot_valid_mem[vw0.idx] <= vw0.data;
        end
        if (vw1.en)
        begin
            slot_valid_mem[vw1.idx] <= vw1.data;
        end
        if (vw0.en && (vw0.idx == vld_rd_addr))
        begin
            vld_rd_reg <= vw0.data;
        end
        else if (vw1.en && (vw1.idx == vld_rd_addr))
        begin
            vld_rd_reg <= vw1.data;
        end
        else
        begin
            vld_rd_reg <= slot_valid_mem[vld_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/dbht_checker.sv @@
// Port-level checker for the doubling bucket hash table, bound to the top level.
`default_nettype none

module dbht_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire dbht_pkg::rsp_t rsp
);
    import dbht_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // an accepted request blocks the next one
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // depth stays within 1..MAX_DEPTH
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.global_depth != '0)
                      && (rsp.global_depth <= DEPTH_W'(MAX_DEPTH)))
        else $error("depth out of range");

    // rejection only at the depth limit
    a_full_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> rsp.global_depth == DEPTH_W'(MAX_DEPTH))
        else $error("insert rejected below depth limit");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK) || (rsp.status == ST_MISS)
                      || (rsp.status == ST_FULL))
        else $error("bad status code");

endmodule

bind doubling_bucket_hash_table dbht_checker u_dbht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

@@ tb/tb_doubling_bucket_hash_table.sv @@
// Self-checking testbench for the doubling bucket hash table: directed and random requests.
`timescale 1ns / 100ps

module tb_doubling_bucket_hash_table;
    import dbht_pkg::*;

    // Opcode 3 is not defined by the block; it should answer with a miss.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Idle cycles tolerated before the run is declared hung. The slowest legal
    // step is a chain of doublings from depth 1 to MAX_DEPTH plus a receiver stall.
    localparam int WATCHDOG_LIMIT = 20000;
    // Quiet time after the last response. Anything that shows up here is a
    // response nobody asked for.
    localparam int SETTLE_CYCLES  = 50;

    typedef struct {
        req_t r;
        bit   drain;   // hold this request back until all responses are in
    } plan_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    doubling_bucket_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow table: same bucket layout as the hardware, updated once per
    // accepted request, in acceptance order.
    // ------------------------------------------------------------------
    logic [31:0]      tbl_key   [NBUCKETS*SLOTS];
    logic [SLOTS-1:0] tbl_valid [NBUCKETS] = '{default: '0};
    int unsigned      tbl_depth = 1;

    // Bucket of a key at depth d: its low d bits.
    function automatic int unsigned bucket_sel(logic [31:0] k, int unsigned d);
        return int'(k & ((32'd1 << d) - 32'd1));
    endfunction

    // Store a key in the lowest free slot of bucket b (no-op if full).
    function automatic void place_key(int unsigned b, logic [31:0] k);
        for (int s = 0; s < SLOTS; s++) begin
            if (!tbl_valid[b][s]) begin
                tbl_key[b*SLOTS+s] = k;
                tbl_valid[b][s]    = 1'b1;
                return;
            end
        end
    endfunction

    // Lowest valid slot of bucket b holding k, SLOTS when absent.
    function automatic int unsigned lookup_slot(int unsigned b, logic [31:0] k);
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_valid[b][s] && tbl_key[b*SLOTS+s] === k) begin
                return s;
            end
        end
        return SLOTS;
    endfunction

    // Apply one request to the shadow table and return the response it owes.
    function automatic rsp_t apply_request(req_t r);
        rsp_t        res;
        int unsigned b;
        int unsigned s;
        int unsigned half;
        int unsigned n;
        logic [31:0] held [SLOTS];
        bit          settled;

        res.status = ST_MISS;
        case (r.op)
            OP_INSERT: begin
                settled = 1'b0;
                while (!settled) begin
                    b = bucket_sel(r.key, tbl_depth);
                    if (tbl_valid[b] != '1) begin
                        place_key(b, r.key);
                        res.status = ST_OK;
                        settled    = 1'b1;
                    end else if (tbl_depth >= MAX_DEPTH) begin
                        // full bucket and no room to grow: drop the key
                        res.status = ST_FULL;
                        settled    = 1'b1;
                    end else begin
                        // double: bucket i splits into i and i + 2^old_depth,
                        // keys keep their relative slot order
                        half = 1 << tbl_depth;
                        tbl_depth++;
                        for (int i = 0; i < half; i++) begin
                            n = 0;
                            for (int j = 0; j < SLOTS; j++) begin
                                if (tbl_valid[i][j]) begin
                                    held[n] = tbl_key[i*SLOTS+j];
                                    n++;
                                end
                            end
                            tbl_valid[i]      = '0;
                            tbl_valid[i+half] = '0;
                            for (int j = 0; j < n; j++) begin
                                place_key(bucket_sel(held[j], tbl_depth), held[j]);
                            end
                        end
                    end
                end
            end
            OP_REMOVE: begin
                b = bucket_sel(r.key, tbl_depth);
                s = lookup_slot(b, r.key);
                if (s < SLOTS) begin
                    tbl_valid[b][s] = 1'b0;
                    res.status      = ST_OK;
                end
            end
            OP_SEARCH: begin
                b = bucket_sel(r.key, tbl_depth);
                if (lookup_slot(b, r.key) < SLOTS) begin
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        res.global_depth = tbl_depth[DEPTH_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request plan
    // ------------------------------------------------------------------
    plan_item_t  req_plan_q [$];
    rsp_t        rsp_expect_q [$];
    logic [31:0] key_pool [$];    // keys believed live, for hits on remove/search
    int          directed_cnt;
    int          total_reqs;

    task automatic queue_request(logic [1:0] op, logic [31:0] key, bit drain);
        plan_item_t p;
        p.r.op  = op;
        p.r.key = key;
        p.drain = drain;
        req_plan_q.insert(req_plan_q.size(), p);
    endtask

    // Random mix. hot_pct: share of keys forced into a few colliding low
    // bytes, which drives doublings and full-table rejects. ins_pct: share of
    // inserts; about 4% are the unused opcode, the rest split between remove
    // and search, mostly on keys already put in.
    task automatic queue_random(int count, int hot_pct, int ins_pct);
        int          pick;
        int          idx;
        bit          drain;
        logic [31:0] k;
        logic [1:0]  op;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom();
            if ($urandom_range(0, 99) < hot_pct) begin
                // low six bits shared, bits 7:6 pick one of four buckets at depth 8
                k[5:0] = 6'h15;
                k[7:6] = 2'($urandom_range(0, 3));
            end
            drain = (n == 0) || ($urandom_range(0, 149) == 0);
            if (pick < ins_pct) begin
                op = OP_INSERT;
                if (key_pool.size() != 0 && $urandom_range(0, 6) == 0) begin
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];  // duplicate
                end
                key_pool.insert(key_pool.size(), k);
            end else if (pick < ins_pct + 4) begin
                op = OP_UNUSED;
            end else begin
                op = (pick % 2 == 0) ? OP_REMOVE : OP_SEARCH;
                if (key_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
                    idx = $urandom_range(0, key_pool.size() - 1);
                    k   = key_pool[idx];
                    if (op == OP_REMOVE) begin
                        key_pool.delete(idx);
                    end
                end
            end
            queue_request(op, k, drain);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: request side, changes inputs on the falling edge. Bursts of
    // random length separated by random gaps; a request marked drain waits
    // until the response queue is empty.
    // ------------------------------------------------------------------
    bit         req_taken = 1'b0;   // request on the bus was accepted last edge
    int         burst_left = 1;
    int         gap_left = 0;
    plan_item_t next_req;

    always @(negedge clk) begin
        if (rst_n && !(req_valid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end else if (req_plan_q.size() == 0 ||
                         (req_plan_q[0].drain && rsp_expect_q.size() != 0)) begin
                req_valid <= 1'b0;
            end else begin
                next_req = req_plan_q.pop_front();
                req       <= next_req.r;
                req_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Response side stall pattern: rotates between no stalls, stalls drawn at
    // random each cycle, and runs of stall/no-stall of random length.
    int unsigned stall_tick = 0;
    int          stall_run = 0;
    bit          stall_lvl = 1'b0;

    always @(negedge clk) begin
        stall_tick++;
        case ((stall_tick / 256) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (stall_run == 0) begin
                    stall_run = $urandom_range(1, 12);
                    stall_lvl = ~stall_lvl;
                end
                stall_run--;
                rsp_stall <= stall_lvl;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge. The accepted request is predicted
    // first, so the expectation is queued before any response is matched.
    // ------------------------------------------------------------------
    int   reqs_accepted = 0;
    int   idle_cycles = 0;
    int   mismatch_cnt = 0;
    int   ok_cnt = 0;
    int   miss_cnt = 0;
    int   full_cnt = 0;
    rsp_t head_rsp;

    always @(posedge clk) begin
        if (rst_n) begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall) begin
                rsp_expect_q.insert(rsp_expect_q.size(), apply_request(req));
                reqs_accepted++;
            end
            if (rsp_valid && !rsp_stall) begin
                if (rsp_expect_q.size() == 0) begin
                    $display("%0t ERROR: unexpected response status %0d depth %0d",
                             $time, rsp.status, rsp.global_depth);
                    mismatch_cnt++;
                end else begin
                    head_rsp = rsp_expect_q.pop_front();
                    if (rsp.status !== head_rsp.status) begin
                        $display("%0t ERROR: status expected %0d, got %0d",
                                 $time, head_rsp.status, rsp.status);
                        mismatch_cnt++;
                    end
                    if (rsp.global_depth !== head_rsp.global_depth) begin
                        $display("%0t ERROR: global_depth expected %0d, got %0d",
                                 $time, head_rsp.global_depth, rsp.global_depth);
                        mismatch_cnt++;
                    end
                    case (head_rsp.status)
                        ST_OK:   ok_cnt++;
                        ST_MISS: miss_cnt++;
                        default: full_cnt++;
                    endcase
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the plan, release reset, wait for the last response.
    // ------------------------------------------------------------------
    bit timed_out;

    initial begin
        // Directed: empty table, duplicates, extreme keys, opcode 3, and a
        // doubling forced by filling bucket 1 at depth 1.
        queue_request(OP_SEARCH, 32'h0000_0000, 1'b0);   // absent search
        queue_request(OP_REMOVE, 32'h0000_0000, 1'b0);   // absent remove
        queue_request(OP_UNUSED, 32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 32'h0000_0000, 1'b0);   // duplicate
        queue_request(OP_SEARCH, 32'h0000_0000, 1'b0);
        queue_request(OP_REMOVE, 32'h0000_0000, 1'b0);
        queue_request(OP_REMOVE, 32'h0000_0000, 1'b0);
        queue_request(OP_REMOVE, 32'h0000_0000, 1'b0);   // now gone
        queue_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < SLOTS - 1; i++) begin
            queue_request(OP_INSERT, 32'(2 * i + 1), 1'b0);
        end
        queue_request(OP_INSERT, 32'(2 * SLOTS + 1), 1'b0);  // bucket full: grows
        queue_request(OP_INSERT, 32'h8000_0000, 1'b0);
        queue_request(OP_SEARCH, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_SEARCH, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_SEARCH, 32'h0000_0005, 1'b0);
        directed_cnt = req_plan_q.size();

        // Random: spread keys at low depth, then a collision-heavy stretch
        // that pushes to MAX_DEPTH and into rejects, then a mixed tail.
        queue_random(500, 0, 35);
        queue_random(250, 80, 70);
        queue_random(450, 30, 40);
        total_reqs = req_plan_q.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(reqs_accepted == total_reqs && rsp_expect_q.size() == 0) &&
               idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
        end
        timed_out = (idle_cycles >= WATCHDOG_LIMIT);
        if (!timed_out) begin
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        if (timed_out) begin
            $display("%0t ERROR: no handshake for %0d cycles, %0d of %0d requests accepted",
                     $time, WATCHDOG_LIMIT, reqs_accepted, total_reqs);
            $display("DONE: errors detected");
        end else begin
            $display("Covered %0d requests (%0d directed): %0d ok, %0d miss, %0d full rejects",
                     reqs_accepted, directed_cnt, ok_cnt, miss_cnt, full_cnt);
            $display("Table grew to depth %0d of %0d", tbl_depth, MAX_DEPTH);
            if (mismatch_cnt == 0) begin
                $display("DONE: 0 errors");
            end else begin
                $display("DONE: errors detected");
            end
        end
        $finish;
    end

endmodule
